FILE: rtl/core/sd7s_pkg.sv
// Types, constants and glyph table shared by the seven-segment encoder files.
package sd7s_pkg;

  localparam int unsigned ValueW = 16;
  localparam int unsigned CodeW  = 7;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned SegW   = 8;
  localparam int unsigned MagW   = 14;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 32;

  localparam logic signed [ValueW-1:0] VALUE_MAX = 16'sd9999;
  localparam logic signed [ValueW-1:0] VALUE_MIN = -16'sd999;

  localparam logic [CodeW-1:0] CODE_UNLIT  = 7'h7f;
  localparam logic [CodeW-1:0] GLYPH_COUNT = 7'd27;
  localparam logic [IdxW-1:0]  GLYPH_MINUS = 5'd16;
  localparam logic [IdxW-1:0]  GLYPH_SPACE = 5'd17;

  localparam logic OP_INTEGER = 1'b0;
  localparam logic OP_RAW     = 1'b1;

  localparam logic DISP_COLON = 1'b0;
  localparam logic DISP_POINT = 1'b1;

  localparam logic [1:0] POINT_NONE = 2'd3;

  localparam logic CFG_DISPLAY_TYPE = 1'b0;
  localparam logic CFG_COLON_ON     = 1'b1;

  typedef struct packed {
    logic                     operation;
    logic signed [ValueW-1:0] value;
    logic                     blank_leading;
    logic [1:0]               point_position;
    logic [3:0][CodeW-1:0]    code;
  } item_t;

  typedef struct packed {
    logic [3:0][SegW-1:0] seg;
    logic                 rejected;
  } result_t;

  typedef struct packed {
    logic display_type;
    logic colon_on;
  } cfg_t;

  function automatic logic [SegW-2:0] glyph(input logic [IdxW-1:0] idx);
    logic [SegW-2:0] g;
    unique case (idx)
      5'd0:  g = 7'h3f;
      5'd1:  g = 7'h06;
      5'd2:  g = 7'h5b;
      5'd3:  g = 7'h4f;
      5'd4:  g = 7'h66;
      5'd5:  g = 7'h6d;
      5'd6:  g = 7'h7d;
      5'd7:  g = 7'h07;
      5'd8:  g = 7'h7f;
      5'd9:  g = 7'h6f;
      5'd10: g = 7'h77;
      5'd11: g = 7'h7c;
      5'd12: g = 7'h39;
      5'd13: g = 7'h5e;
      5'd14: g = 7'h79;
      5'd15: g = 7'h71;
      5'd16: g = 7'h40;
      5'd17: g = 7'h00;
      5'd18: g = 7'h63;
      5'd19: g = 7'h50;
      5'd20: g = 7'h74;
      5'd21: g = 7'h54;
      5'd22: g = 7'h78;
      5'd23: g = 7'h6a;
      5'd24: g = 7'h1d;
      5'd25: g = 7'h5c;
      5'd26: g = 7'h73;
      default: g = 7'h00;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/core/sd7s_encode.sv
// Combinational encoder: one request plus configuration to four segment bytes.
module sd7s_encode
  import sd7s_pkg::*;
(
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic                     out_of_range;
  logic                     neg;
  logic signed [ValueW-1:0] neg_value;
  logic [MagW-1:0]          mag;
  logic [30:0]              p10;
  logic [26:0]              p100;
  logic [26:0]              p1000;
  logic [9:0]               q10;
  logic [6:0]               q100;
  logic [3:0]               q1000;
  logic [MagW-1:0]          r3;
  logic [9:0]               r2;
  logic [6:0]               r1;
  logic [3:0]               d0, d1, d2, d3;
  logic [3:0][IdxW-1:0]     idx;
  logic [3:0]               unlit;
  logic                     bad;
  logic                     colon_bit;
  logic [3:0][SegW-1:0]     seg;

  assign out_of_range = (item.value > VALUE_MAX) || (item.value < VALUE_MIN);
  assign neg          = item.value[ValueW-1];
  assign neg_value    = -item.value;
  assign mag          = neg ? neg_value[MagW-1:0] : item.value[MagW-1:0];

  // divide by 10, 100 and 1000 through reciprocal multiplication
  assign p10   = 31'(mag) * 31'd52429;
  assign p100  = 27'(mag) * 27'd5243;
  assign p1000 = 27'(mag) * 27'd8389;
  assign q10   = p10[28:19];
  assign q100  = p100[25:19];
  assign q1000 = p1000[26:23];

  assign r3 = mag - 14'({q10, 3'b000} + {q10, 1'b0});
  assign r2 = q10 - 10'({q100, 3'b000} + {q100, 1'b0});
  assign r1 = q100 - 7'({q1000, 3'b000} + {q1000, 1'b0});
  assign d0 = q1000;
  assign d1 = r1[3:0];
  assign d2 = r2[3:0];
  assign d3 = r3[3:0];

  assign colon_bit = (cfg.display_type == DISP_COLON) && cfg.colon_on;

  always_comb begin
    idx   = '0;
    unlit = '0;
    bad   = 1'b0;
    if (item.operation == OP_INTEGER) begin
      bad = out_of_range;
      if (neg) begin
        idx[0] = GLYPH_MINUS;
        idx[1] = IdxW'(d1);
        idx[2] = IdxW'(d2);
        idx[3] = IdxW'(d3);
        if (item.blank_leading && d1 == 4'd0) begin
          idx[1] = GLYPH_SPACE;
          if (d2 == 4'd0) begin
            idx[2] = GLYPH_SPACE;
          end
        end
      end else begin
        idx[0] = IdxW'(d0);
        idx[1] = IdxW'(d1);
        idx[2] = IdxW'(d2);
        idx[3] = IdxW'(d3);
        if (item.blank_leading && d0 == 4'd0) begin
          idx[0] = GLYPH_SPACE;
          if (d1 == 4'd0) begin
            idx[1] = GLYPH_SPACE;
            if (d2 == 4'd0) begin
              idx[2] = GLYPH_SPACE;
            end
          end
        end
      end
    end else begin
      for (int k = 0; k < 4; k++) begin
        unlit[k] = (item.code[k] == CODE_UNLIT);
        idx[k]   = item.code[k][IdxW-1:0];
        if (!unlit[k] && item.code[k] >= GLYPH_COUNT) begin
          bad = 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      seg[k] = unlit[k] ? '0 : {colon_bit, glyph(idx[k])};
    end
    if (cfg.display_type == DISP_POINT && item.point_position != POINT_NONE) begin
      seg[item.point_position][SegW-1] = 1'b1;
    end
    if (bad) begin
      seg = '0;
    end
  end

  assign res.seg      = seg;
  assign res.rejected = bad;

endmodule

FILE: rtl/core/signed_decimal_to_seven_segment.sv
// Top level: four-digit seven-segment encoder with request and result streams.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+---------------------------------------
//   in_     | in  | in_tvalid/tready   | tuser operation, tdata value..code_3
//   out_    | out | out_tvalid/tready  | tuser rejected, tdata seg_0..seg_3
//   cfg_    | in  | cfg_wr_en          | cfg_addr index, cfg_wdata value
//
// One request per cycle while results are taken; stages: request register, result register.
// Both stages advance whenever the result register is empty or being taken.
// rst_n (synchronous) clears both valid flags and the configuration registers.
// A stalled result holds the result and request registers; no request is lost.
module signed_decimal_to_seven_segment
  import sd7s_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [15:0] value, [16] blank_leading, [18:17] point_position,
  // [25:19] code_0, [32:26] code_1, [39:33] code_2, [46:40] code_3, [47] zero
  input  logic [InDataW-1:0]  in_tdata,
  // [0] operation
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // [7:0] seg_0, [15:8] seg_1, [23:16] seg_2, [31:24] seg_3
  output logic [OutDataW-1:0] out_tdata,
  // [0] rejected
  output logic                out_tuser,
  input  logic                cfg_wr_en,
  input  logic                cfg_addr,
  input  logic                cfg_wdata
);

  cfg_t    cfg_r;
  logic    in_v_r;
  item_t   item_r;
  item_t   item_nxt;
  logic    out_v_r;
  result_t res_r;
  result_t res_nxt;
  logic    advance;

  assign advance   = !out_v_r || out_tready;
  assign in_tready = !in_v_r || advance;

  always_comb begin
    item_nxt.operation      = in_tuser;
    item_nxt.value          = in_tdata[15:0];
    item_nxt.blank_leading  = in_tdata[16];
    item_nxt.point_position = in_tdata[18:17];
    item_nxt.code[0]        = in_tdata[25:19];
    item_nxt.code[1]        = in_tdata[32:26];
    item_nxt.code[2]        = in_tdata[39:33];
    item_nxt.code[3]        = in_tdata[46:40];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_DISPLAY_TYPE: cfg_r.display_type <= cfg_wdata;
        CFG_COLON_ON:     cfg_r.colon_on     <= cfg_wdata;
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r <= in_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_nxt;
    end
    if (advance && in_v_r) begin
      res_r <= res_nxt;
    end
  end

  sd7s_encode u_encode (
    .item (item_r),
    .cfg  (cfg_r),
    .res  (res_nxt)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = res_r.seg;
  assign out_tuser  = res_r.rejected;

endmodule

FILE: rtl/core/sd7s_check.sv
// Port-level checker for the seven-segment encoder, bound to the top level.
module sd7s_check
  import sd7s_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata,
  input logic                out_tuser
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_reject_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("rejected result carries segments");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("request stalled with empty result register");

endmodule

bind signed_decimal_to_seven_segment sd7s_check u_sd7s_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
